// ===== rtl/wfd_pkg.sv =====
// Package for the wall-follow drive controller: state codes, reset values of
// the configuration registers and the structs passed between modules.
// No dependencies.
`default_nettype none

package wfd_pkg;

  localparam int RANGE_W   = 16;
  localparam int ANGLE_W   = 13;
  localparam int SPEED_W   = 10;
  localparam int RATE_W    = 13;
  localparam int ANG_CMD_W = 14;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [MODE_W-1:0] ST_CHOOSE  = 3'd0;
  localparam logic [MODE_W-1:0] ST_FORWARD = 3'd1;
  localparam logic [MODE_W-1:0] ST_RIGHT   = 3'd2;
  localparam logic [MODE_W-1:0] ST_LEFT    = 3'd3;
  localparam logic [MODE_W-1:0] ST_LEFT90  = 3'd4;
  localparam logic [MODE_W-1:0] ST_SLOW    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_DIST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NO_WALL_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_TURN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd7;

  localparam logic [RANGE_W-1:0] FORWARD_DIST_RST = 16'd400;
  localparam logic [RANGE_W-1:0] SIDE_DIST_RST    = 16'd400;
  localparam logic [RANGE_W-1:0] NO_WALL_DIST_RST = 16'd570;
  localparam logic [ANGLE_W-1:0] SMALL_TURN_RST   = 13'd35;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN_RST = 13'd1571;
  localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 10'd300;
  localparam logic [RATE_W-1:0]  TURN_RATE_RST    = 13'd1500;
  localparam logic [RANGE_W-1:0] RANGE_MAX_RST    = 16'd3500;

  typedef struct packed {
    logic [RANGE_W-1:0] forward_dist_mm;
    logic [RANGE_W-1:0] side_dist_mm;
    logic [RANGE_W-1:0] no_wall_dist_mm;
    logic [ANGLE_W-1:0] small_turn_mrad;
    logic [ANGLE_W-1:0] quarter_turn_mrad;
    logic [SPEED_W-1:0] cruise_speed;
    logic [RATE_W-1:0]  turn_rate;
    logic [RANGE_W-1:0] range_max_mm;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0]        front_mm;
    logic [RANGE_W-1:0]        left_mm;
    logic [RANGE_W-1:0]        right_mm;
    logic [RANGE_W-1:0]        abeam_mm;
    logic                      front_inf;
    logic                      left_inf;
    logic                      right_inf;
    logic                      abeam_inf;
    logic signed [ANGLE_W-1:0] heading_mrad;
  } item_t;

  typedef struct packed {
    logic                        emit;
    logic [SPEED_W-1:0]          linear_cmd;
    logic signed [ANG_CMD_W-1:0] angular_cmd;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/wfd_cfg_regs.sv =====
// Configuration register file of the wall-follow drive controller.
// Depends on wfd_pkg.
`default_nettype none

module wfd_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wfd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output wfd_pkg::cfg_t                      cfg
);
  import wfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_dist_mm   <= FORWARD_DIST_RST;
      cfg.side_dist_mm      <= SIDE_DIST_RST;
      cfg.no_wall_dist_mm   <= NO_WALL_DIST_RST;
      cfg.small_turn_mrad   <= SMALL_TURN_RST;
      cfg.quarter_turn_mrad <= QUARTER_TURN_RST;
      cfg.cruise_speed      <= CRUISE_SPEED_RST;
      cfg.turn_rate         <= TURN_RATE_RST;
      cfg.range_max_mm      <= RANGE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORWARD_DIST: cfg.forward_dist_mm   <= cfg_wdata;
        REG_SIDE_DIST:    cfg.side_dist_mm      <= cfg_wdata;
        REG_NO_WALL_DIST: cfg.no_wall_dist_mm   <= cfg_wdata;
        REG_SMALL_TURN:   cfg.small_turn_mrad   <= cfg_wdata[ANGLE_W-1:0];
        REG_QUARTER_TURN: cfg.quarter_turn_mrad <= cfg_wdata[ANGLE_W-1:0];
        REG_CRUISE_SPEED: cfg.cruise_speed      <= cfg_wdata[SPEED_W-1:0];
        REG_TURN_RATE:    cfg.turn_rate         <= cfg_wdata[RATE_W-1:0];
        REG_RANGE_MAX:    cfg.range_max_mm      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wfd_ctrl.sv =====
// Wall-follow state machine: mode and saved readings, next-state and command
// logic for one registered tick. Depends on wfd_pkg.
`default_nettype none

module wfd_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire wfd_pkg::item_t              item,
  input  wire wfd_pkg::cfg_t               cfg,
  output wfd_pkg::cmd_t                    cmd,
  output logic [wfd_pkg::MODE_W-1:0]       mode
);
  import wfd_pkg::*;

  logic signed [ANGLE_W-1:0] saved_heading;
  logic [RANGE_W-1:0]        saved_left;
  logic [RANGE_W-1:0]        saved_abeam;

  logic [MODE_W-1:0]         mode_next;
  logic signed [ANGLE_W-1:0] saved_heading_next;
  logic [RANGE_W-1:0]        saved_left_next;
  logic [RANGE_W-1:0]        saved_abeam_next;

  logic [RANGE_W-1:0]        front, left, right, hleft, side;
  logic signed [ANGLE_W:0]   diff;
  logic [ANGLE_W-1:0]        adiff;
  logic                      small_done, quarter_done;
  logic [19:0]               left_x10, side_x13;
  logic [17:0]               left_x2, saved_left_x2, side_x3;
  logic [17:0]               div10_prod;
  logic [SPEED_W-1:0]        speed_half, speed_tenth;
  logic signed [ANG_CMD_W-1:0] rate_pos;
  logic                      r_left_close, r_right_close, r_wall_gone, r_approach, r_far;

  assign front = item.front_inf ? cfg.range_max_mm : item.front_mm;
  assign left  = item.left_inf  ? cfg.range_max_mm : item.left_mm;
  assign right = item.right_inf ? cfg.range_max_mm : item.right_mm;
  assign hleft = item.abeam_inf ? cfg.range_max_mm : item.abeam_mm;
  assign side  = cfg.side_dist_mm;

  // no heading wrap: plain signed difference
  assign diff  = (ANGLE_W+1)'(saved_heading) - (ANGLE_W+1)'(item.heading_mrad);
  assign adiff = diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
  assign small_done   = adiff >= cfg.small_turn_mrad;
  assign quarter_done = adiff >= cfg.quarter_turn_mrad;

  assign left_x10      = 20'(left) * 20'd10;
  assign side_x13      = 20'(side) * 20'd13;
  assign left_x2       = {1'b0, left, 1'b0};
  assign saved_left_x2 = {1'b0, saved_left, 1'b0};
  assign side_x3       = 18'(side) * 18'd3;

  assign r_left_close  = left < side;
  assign r_right_close = right < side;
  assign r_wall_gone   = (hleft > cfg.no_wall_dist_mm) &&
                         (saved_abeam <= cfg.no_wall_dist_mm);
  assign r_approach    = (left > saved_left) && (left_x10 > side_x13) &&
                         ({1'b0, left} < {side, 1'b0});
  assign r_far         = (left_x2 > side_x3) && (saved_left_x2 > side_x3);

  // x/10 as (x*205)>>11, exact over the 10-bit speed range
  assign div10_prod  = 18'(cfg.cruise_speed) * 18'd205;
  assign speed_tenth = SPEED_W'(div10_prod[17:11]);
  assign speed_half  = {1'b0, cfg.cruise_speed[SPEED_W-1:1]};
  assign rate_pos    = {1'b0, cfg.turn_rate};

  always_comb begin
    mode_next          = mode;
    saved_heading_next = saved_heading;
    saved_left_next    = saved_left;
    saved_abeam_next   = saved_abeam;
    cmd                = '0;
    unique case (mode)
      ST_CHOOSE: begin
        if (front > cfg.forward_dist_mm) begin
          saved_left_next    = left;
          saved_abeam_next   = hleft;
          saved_heading_next = item.heading_mrad;
          if (r_left_close)       mode_next = ST_RIGHT;
          else if (r_right_close) mode_next = ST_LEFT;
          else if (r_wall_gone)   mode_next = ST_LEFT90;
          else if (r_approach)    mode_next = ST_LEFT;
          else if (r_far)         mode_next = ST_SLOW;
          else begin
            mode_next          = ST_FORWARD;
            saved_heading_next = saved_heading;
          end
        end else if (front < cfg.forward_dist_mm) begin
          saved_left_next    = left;
          saved_abeam_next   = hleft;
          saved_heading_next = item.heading_mrad;
          mode_next          = ST_RIGHT;
        end
      end
      ST_FORWARD: begin
        mode_next      = ST_CHOOSE;
        cmd.emit       = 1'b1;
        cmd.linear_cmd = cfg.cruise_speed;
      end
      ST_SLOW: begin
        mode_next      = ST_CHOOSE;
        cmd.emit       = 1'b1;
        cmd.linear_cmd = speed_half;
      end
      ST_RIGHT: begin
        if (small_done) mode_next = ST_CHOOSE;
        else begin
          cmd.emit        = 1'b1;
          cmd.angular_cmd = -rate_pos;
        end
      end
      ST_LEFT: begin
        if (small_done) mode_next = ST_CHOOSE;
        else begin
          cmd.emit        = 1'b1;
          cmd.angular_cmd = rate_pos;
        end
      end
      ST_LEFT90: begin
        if (quarter_done) mode_next = ST_CHOOSE;
        else begin
          cmd.emit        = 1'b1;
          cmd.linear_cmd  = speed_tenth;
          cmd.angular_cmd = rate_pos;
        end
      end
      default: mode_next = ST_CHOOSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ST_CHOOSE;
      saved_heading <= '0;
      saved_left    <= '0;
      saved_abeam   <= '0;
    end else if (adv) begin
      mode          <= mode_next;
      saved_heading <= saved_heading_next;
      saved_left    <= saved_left_next;
      saved_abeam   <= saved_abeam_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wall_follow_drive_fsm.sv =====
// Top level of the wall-follow drive controller: input register, state
// machine step and command output register. Depends on wfd_pkg,
// wfd_cfg_regs and wfd_ctrl.
//
//   channel  direction  tdata                                  tuser
//   s_       in         ranges and heading                     infinity flags
//   m_       out        linear and angular command             -
//   cfg_     in         register write, index and value        -
//
// One tick per cycle unless the output stalls; a tick waits in the input
// register, where the state machine steps, and its command (if any) sits in
// the output register until taken. Ticks that publish nothing produce no
// transfer. A stalled output holds the state machine and a full input
// register. Synchronous reset restores registers and choose-direction state.
`default_nettype none

module wall_follow_drive_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // front_mm[15:0], left_mm[31:16], right_mm[47:32], abeam_mm[63:48],
  // heading_mrad[76:64], zero pad [79:77]
  input  wire logic [79:0] s_tdata,
  // front_inf[0], left_inf[1], right_inf[2], abeam_inf[3]
  input  wire logic [3:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // linear_cmd[9:0], angular_cmd[23:10]
  output logic [23:0]      m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [wfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wfd_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import wfd_pkg::*;

  cfg_t              cfg;
  item_t             item;
  cmd_t              cmd;
  logic              in_valid;
  logic              adv;
  logic [MODE_W-1:0] mode;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  wfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.front_mm     <= s_tdata[15:0];
      item.left_mm      <= s_tdata[31:16];
      item.right_mm     <= s_tdata[47:32];
      item.abeam_mm     <= s_tdata[63:48];
      item.heading_mrad <= s_tdata[76:64];
      item.front_inf    <= s_tuser[0];
      item.left_inf     <= s_tuser[1];
      item.right_inf    <= s_tuser[2];
      item.abeam_inf    <= s_tuser[3];
    end
  end

  wfd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (item),
    .cfg  (cfg),
    .cmd  (cmd),
    .mode (mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= cmd.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.emit) begin
      m_tdata <= {cmd.angular_cmd, cmd.linear_cmd};
    end
  end

  a_choose_silent: assert property (@(posedge clk) disable iff (rst)
    (adv && mode == ST_CHOOSE) |=> !m_tvalid)
    else $error("choose-direction tick produced a command");

  a_straight_cmd: assert property (@(posedge clk) disable iff (rst)
    (adv && (mode == ST_FORWARD || mode == ST_SLOW)) |=>
      (m_tvalid && m_tdata[23:10] == '0 && mode == ST_CHOOSE))
    else $error("straight drive tick gave a wrong command or state");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> (in_valid && $stable(mode)))
    else $error("state machine stepped while output stalled");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input refused with empty input register");

endmodule

`default_nettype wire
